FILE: design/mexp_pkg.sv
package mexp_pkg;

  localparam int VALUE_WIDTH    = 31;
  localparam int EXPONENT_WIDTH = 32;
  localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
  localparam int CFG_DATA_WIDTH = (EXPONENT_WIDTH > VALUE_WIDTH) ? EXPONENT_WIDTH : VALUE_WIDTH;
  localparam int CFG_INDEX_WIDTH = 1;

  // Two product bits are folded into the remainder per reduction cycle.
  localparam int RED_CYCLES = PROD_WIDTH / 2;
  localparam int CNT_WIDTH  = $clog2(RED_CYCLES);

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 1'b1;

  localparam logic [EXPONENT_WIDTH-1:0] EXPONENT_RESET = EXPONENT_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0]    MODULUS_RESET  = VALUE_WIDTH'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_MULT,
    ST_REDUCE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic reduce;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bits_zero;
    logic red_last;
    logic out_free;
  } status_t;

endpackage

FILE: design/mexp_ctrl.sv
module mexp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd
);

  mexp_pkg::state_t state_r;
  mexp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mexp_pkg::ST_LOOP;
      end
      mexp_pkg::ST_LOOP: begin
        state_nxt = status.bits_zero ? mexp_pkg::ST_DONE : mexp_pkg::ST_MULT;
      end
      mexp_pkg::ST_MULT: begin
        state_nxt = mexp_pkg::ST_REDUCE;
      end
      mexp_pkg::ST_REDUCE: begin
        if (status.red_last) state_nxt = mexp_pkg::ST_UPDATE;
      end
      mexp_pkg::ST_UPDATE: begin
        state_nxt = mexp_pkg::ST_LOOP;
      end
      mexp_pkg::ST_DONE: begin
        if (status.out_free) state_nxt = mexp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mexp_pkg::ST_LOOP: begin
      end
      mexp_pkg::ST_MULT: begin
        cmd.mult = 1'b1;
      end
      mexp_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
      end
      mexp_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      mexp_pkg::ST_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_reduce_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_REDUCE && !status.red_last) |=> state_r == mexp_pkg::ST_REDUCE)
    else $error("reduction left before its last cycle");
  a_update_after_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_UPDATE) |-> $past(state_r) == mexp_pkg::ST_REDUCE)
    else $error("update without a finished reduction");
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_DONE && !status.out_free) |=> state_r == mexp_pkg::ST_DONE)
    else $error("result handoff left while the output was full");
`endif

endmodule

FILE: design/mexp_dp.sv
module mexp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mexp_pkg::cmd_t                      cmd,
  output mexp_pkg::status_t                   status,
  input  logic [mexp_pkg::VALUE_WIDTH-1:0]    base_value,
  input  logic [mexp_pkg::EXPONENT_WIDTH-1:0] exponent,
  input  logic [mexp_pkg::VALUE_WIDTH-1:0]    modulus,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mexp_pkg::VALUE_WIDTH-1:0]    out_power_result
);

  localparam int VW = mexp_pkg::VALUE_WIDTH;
  localparam int PW = mexp_pkg::PROD_WIDTH;
  localparam int CW = mexp_pkg::CNT_WIDTH;
  localparam logic [CW-1:0] CNT_LAST = CW'(mexp_pkg::RED_CYCLES - 1);

  logic [VW-1:0]                      acc_r;
  logic [VW-1:0]                      power_r;
  logic [VW-1:0]                      mod_r;
  logic [mexp_pkg::EXPONENT_WIDTH-1:0] bits_r;
  logic [PW-1:0]                      prod_a_r;
  logic [PW-1:0]                      prod_p_r;
  logic [VW-1:0]                      rem_a_r;
  logic [VW-1:0]                      rem_p_r;
  logic [CW-1:0]                      cnt_r;
  logic                               out_valid_r;
  logic [VW-1:0]                      out_data_r;

  logic [PW-1:0] mul_a;
  logic [PW-1:0] mul_p;
  logic [VW-1:0] rem_a_nxt;
  logic [VW-1:0] rem_p_nxt;
  logic          mod_zero;

  // One restoring remainder step: shift in a product bit, subtract if it fits.
  function automatic logic [VW-1:0] rem_step(input logic [VW-1:0] r, input logic b,
                                             input logic [VW-1:0] m);
    logic [VW:0] t;
    begin
      t = {r, b};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      return t[VW-1:0];
    end
  endfunction

  assign mul_a    = PW'(acc_r) * PW'(power_r);
  assign mul_p    = PW'(power_r) * PW'(power_r);
  assign mod_zero = (mod_r == '0);

  assign rem_a_nxt = rem_step(rem_step(rem_a_r, prod_a_r[PW-1], mod_r), prod_a_r[PW-2], mod_r);
  assign rem_p_nxt = rem_step(rem_step(rem_p_r, prod_p_r[PW-1], mod_r), prod_p_r[PW-2], mod_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r   <= VW'(1);
      power_r <= base_value;
      bits_r  <= exponent;
      mod_r   <= modulus;
    end
    if (cmd.mult) begin
      prod_a_r <= mul_a;
      prod_p_r <= mul_p;
      rem_a_r  <= '0;
      rem_p_r  <= '0;
      cnt_r    <= '0;
    end
    if (cmd.reduce) begin
      prod_a_r <= {prod_a_r[PW-3:0], 2'b00};
      prod_p_r <= {prod_p_r[PW-3:0], 2'b00};
      rem_a_r  <= rem_a_nxt;
      rem_p_r  <= rem_p_nxt;
      cnt_r    <= cnt_r + CW'(1);
    end
    if (cmd.update) begin
      // A zero modulus reduces everything to zero.
      if (bits_r[0]) acc_r <= mod_zero ? '0 : rem_a_r;
      power_r <= mod_zero ? '0 : rem_p_r;
      bits_r  <= bits_r >> 1;
    end
    if (cmd.emit) begin
      out_data_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.bits_zero = (bits_r == '0);
  assign status.red_last  = (cnt_r == CNT_LAST);
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

`ifndef SYNTHESIS
  a_load_acc_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> acc_r == VW'(1))
    else $error("accumulator not set to one at start");
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.reduce) && !mod_zero) |-> (rem_a_r < mod_r && rem_p_r < mod_r))
    else $error("partial remainder not below modulus");
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");
`endif

endmodule

FILE: design/modular_exponentiation.sv
// Modular exponentiation, right-to-left binary square-and-multiply.
// The loop runs once per exponent bit up to the highest set one; a zero exponent ends it at once.
// Each exponent bit costs a loop check, a multiply, a reduction of both products and an update.
// A new base is taken only after the last result is emitted; the next beat is taken the cycle after emit.
// Reset (rst_n low, synchronous): controller idle, output empty, exponent = 1, modulus = 1.
module modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mexp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  // input channel: one base value per beat
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mexp_pkg::VALUE_WIDTH-1:0]     in_base_value,
  // result channel: one power per beat
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mexp_pkg::VALUE_WIDTH-1:0]     out_power_result
);

  logic [mexp_pkg::EXPONENT_WIDTH-1:0] exponent_r;
  logic [mexp_pkg::VALUE_WIDTH-1:0]    modulus_r;

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  // Configuration registers; bits above a register's width are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= mexp_pkg::EXPONENT_RESET;
      modulus_r  <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mexp_pkg::CFG_EXPONENT: exponent_r <= cfg_data[mexp_pkg::EXPONENT_WIDTH-1:0];
        mexp_pkg::CFG_MODULUS:  modulus_r  <= cfg_data[mexp_pkg::VALUE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller: sequences load, per-bit multiply / reduce / update, then hands off the result.
  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: two parallel multiply-and-reduce lanes (accumulator and square) plus the
  // output register that decouples the result beat from the next input beat.
  mexp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .base_value       (in_base_value),
    .exponent         (exponent_r),
    .modulus          (modulus_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

endmodule

FILE: tb/tb_modular_exponentiation.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation;

  localparam logic [mexp_pkg::VALUE_WIDTH-1:0] VALUE_MAX = '1;
  // Receiver hold-off long enough to fill the block and back up the input.
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 540;
  // Wait at the end a little longer than a full 32-bit exponent takes.
  localparam int DRAIN_CYCLES = 1200;

  logic                                 clk           = 1'b0;
  logic                                 rst_n         = 1'b0;
  logic                                 cfg_wr_en     = 1'b0;
  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index     = mexp_pkg::CFG_EXPONENT;
  logic [mexp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data      = '0;
  logic                                 in_valid      = 1'b0;
  logic                                 in_stall;
  logic [mexp_pkg::VALUE_WIDTH-1:0]     in_base_value = '0;
  logic                                 out_valid;
  logic                                 out_stall     = 1'b0;
  logic [mexp_pkg::VALUE_WIDTH-1:0]     out_power_result;

  // Shadow copies of the configuration, used by the predictor.
  logic [mexp_pkg::EXPONENT_WIDTH-1:0] exponent_shadow = mexp_pkg::EXPONENT_RESET;
  logic [mexp_pkg::VALUE_WIDTH-1:0]    modulus_shadow  = mexp_pkg::MODULUS_RESET;

  logic [mexp_pkg::VALUE_WIDTH-1:0] pending_bases[$];
  logic [mexp_pkg::VALUE_WIDTH-1:0] expected_powers[$];

  int error_count   = 0;
  int results_seen  = 0;
  int tx_gap        = 0;
  int rx_wait       = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;
  bit tx_gaps_on    = 1'b1;
  bit rx_gaps_on    = 1'b1;

  modular_exponentiation u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Reduce a double-width product; a zero modulus collapses everything to zero.
  function automatic logic [63:0] reduce_mod(input logic [63:0] product);
    if (modulus_shadow == '0) return 64'd0;
    return product % {33'd0, modulus_shadow};
  endfunction

  // Right-to-left square-and-multiply. The base goes in unreduced and the
  // accumulator starts at 1, so a zero exponent yields 1 whatever the modulus.
  function automatic logic [mexp_pkg::VALUE_WIDTH-1:0] predict_power(
      input logic [mexp_pkg::VALUE_WIDTH-1:0] base);
    logic [63:0]                         square;
    logic [63:0]                         acc;
    logic [mexp_pkg::EXPONENT_WIDTH-1:0] bits;
    square = {33'd0, base};
    acc    = 64'd1;
    bits   = exponent_shadow;
    while (bits != '0) begin
      if (bits[0]) acc = reduce_mod(acc * square);
      bits   = bits >> 1;
      square = reduce_mod(square * square);
    end
    return acc[mexp_pkg::VALUE_WIDTH-1:0];
  endfunction

  // Append one base to the driver's queue.
  task automatic queue_base(input logic [mexp_pkg::VALUE_WIDTH-1:0] base);
    pending_bases.insert(pending_bases.size(), base);
  endtask

  // Driver: hold the beat while stalled, otherwise wait out the drawn gap and
  // present the next pending base. Predict at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_powers.insert(expected_powers.size(), predict_power(in_base_value));
      end
      if (tx_gap != 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bases.size() != 0) begin
        in_base_value <= pending_bases.pop_front();
        in_valid      <= 1'b1;
        tx_gap        <= tx_gaps_on ? int'($urandom_range(0, 7)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver: check each accepted beat against the oldest
  // prediction, then draw the stall before the next one.
  always @(posedge clk) begin : rx_side
    logic [mexp_pkg::VALUE_WIDTH-1:0] want;
    int                               draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_powers.size() == 0) begin
          $display("%0t: power_result %0d with nothing expected", $time, out_power_result);
          error_count++;
        end else begin
          want = expected_powers.pop_front();
          if (out_power_result !== want) begin
            $display("%0t: power_result mismatch: expected %0d, actual %0d",
                     $time, want, out_power_result);
            error_count++;
          end
        end
        results_seen++;
        // Once, with the sender still loaded, block the output for a long stretch.
        if (!pressure_done && results_seen >= 40 && pending_bases.size() >= 4) begin
          hold_left     <= HOLD_CYCLES;
          pressure_done <= 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        draw      = rx_gaps_on ? int'($urandom_range(0, 7)) : 0;
        out_stall <= (draw != 0);
        rx_wait   <= (draw != 0) ? draw - 1 : 0;
      end else if (rx_wait != 0) begin
        rx_wait   <= rx_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register; keep the enable high for back-to-back writes.
  task automatic write_reg(input logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] index,
                           input logic [mexp_pkg::CFG_DATA_WIDTH-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    if (index == mexp_pkg::CFG_EXPONENT) begin
      exponent_shadow = data[mexp_pkg::EXPONENT_WIDTH-1:0];
    end else begin
      modulus_shadow = data[mexp_pkg::VALUE_WIDTH-1:0];
    end
  endtask

  // Drop the enable and land on a falling edge, clear of the clocked processes.
  task automatic end_config();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Advance until every pending base went in and every result came back.
  task automatic drain();
    do @(negedge clk);
    while (!(pending_bases.size() == 0 && !in_valid && expected_powers.size() == 0));
  endtask

  initial begin : stimulus
    logic [mexp_pkg::EXPONENT_WIDTH-1:0] exp_pick;
    logic [mexp_pkg::CFG_DATA_WIDTH-1:0] mod_pick;
    logic [mexp_pkg::VALUE_WIDTH-1:0]    mod_now;
    int                                  phase_items;
    int                                  queued;
    queued = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: exponent 1, modulus 1, so every base reduces to zero.
    queue_base('0);
    queue_base(VALUE_MAX);
    drain();

    // Zero exponent returns 1 unreduced, even with modulus 1.
    write_reg(mexp_pkg::CFG_EXPONENT, 32'd0);
    end_config();
    queue_base(31'd12345);
    queue_base(VALUE_MAX);
    drain();

    // Widest exponent and modulus; a base equal to the modulus goes in as is.
    write_reg(mexp_pkg::CFG_EXPONENT, 32'hFFFF_FFFF);
    write_reg(mexp_pkg::CFG_MODULUS, 32'h7FFF_FFFF);
    end_config();
    queue_base('0);
    queue_base(31'd1);
    queue_base(31'd2);
    queue_base(VALUE_MAX);
    queue_base(VALUE_MAX - 31'd1);
    drain();

    // Modulus zero through a write whose only set bit lies above the register.
    write_reg(mexp_pkg::CFG_EXPONENT, 32'd2);
    write_reg(mexp_pkg::CFG_MODULUS, 32'h8000_0000);
    end_config();
    queue_base(31'd5);
    queue_base(VALUE_MAX);
    drain();

    // Zero exponent still gives 1 with a zero modulus.
    write_reg(mexp_pkg::CFG_EXPONENT, 32'd0);
    end_config();
    queue_base(31'd7);
    drain();

    write_reg(mexp_pkg::CFG_EXPONENT, 32'h0001_0001);
    write_reg(mexp_pkg::CFG_MODULUS, 32'd2);
    end_config();
    queue_base(31'd3);
    queue_base(31'd2);
    drain();

    // Prime modulus with bases just below, at and above it.
    write_reg(mexp_pkg::CFG_EXPONENT, 32'hDEAD_BEEF);
    write_reg(mexp_pkg::CFG_MODULUS, 32'd1_000_003);
    end_config();
    queue_base(31'd1_000_002);
    queue_base(31'd1_000_003);
    queue_base(31'd1_000_004);
    queue_base(31'h4000_0000);
    drain();

    // Only the top exponent bit set: a long run of squarings, one multiply.
    write_reg(mexp_pkg::CFG_EXPONENT, 32'h8000_0000);
    write_reg(mexp_pkg::CFG_MODULUS, 32'h7FFF_FFFE);
    end_config();
    queue_base(mexp_pkg::VALUE_WIDTH'($urandom));
    queue_base(mexp_pkg::VALUE_WIDTH'($urandom));
    drain();

    // Random phases: new settings each time, bases mixed around the modulus.
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       exp_pick = '0;
        1:       exp_pick = '1;
        2, 3, 4: exp_pick = $urandom;
        default: exp_pick = $urandom >> $urandom_range(0, 31);
      endcase
      mod_pick = $urandom;
      case ($urandom_range(0, 9))
        0:       mod_pick[mexp_pkg::VALUE_WIDTH-1:0] = mexp_pkg::VALUE_WIDTH'(1);
        1:       mod_pick[mexp_pkg::VALUE_WIDTH-1:0] = VALUE_MAX;
        2:       mod_pick[mexp_pkg::VALUE_WIDTH-1:0] =
                   mexp_pkg::VALUE_WIDTH'($urandom_range(2, 255));
        default: if (mod_pick[mexp_pkg::VALUE_WIDTH-1:0] == '0) mod_pick[0] = 1'b1;
      endcase
      mod_now = mod_pick[mexp_pkg::VALUE_WIDTH-1:0];
      if ($urandom_range(0, 1) != 0) begin
        write_reg(mexp_pkg::CFG_EXPONENT, mexp_pkg::CFG_DATA_WIDTH'(exp_pick));
        write_reg(mexp_pkg::CFG_MODULUS, mod_pick);
      end else begin
        write_reg(mexp_pkg::CFG_MODULUS, mod_pick);
        write_reg(mexp_pkg::CFG_EXPONENT, mexp_pkg::CFG_DATA_WIDTH'(exp_pick));
      end
      end_config();
      // Leave some phases free of gaps on either side.
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      phase_items = $urandom_range(15, 50);
      repeat (phase_items) begin
        case ($urandom_range(0, 15))
          0:       queue_base('0);
          1:       queue_base(VALUE_MAX);
          2:       queue_base(mod_now - mexp_pkg::VALUE_WIDTH'(1));
          3:       queue_base(mod_now);
          4:       queue_base(mexp_pkg::VALUE_WIDTH'($urandom_range(0, 15)));
          5:       queue_base(mexp_pkg::VALUE_WIDTH'($urandom % mod_now));
          default: queue_base(mexp_pkg::VALUE_WIDTH'($urandom));
        endcase
      end
      queued += phase_items;
      drain();
    end

    // Hold on for stray results before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/mexp_pkg.sv
design/mexp_ctrl.sv
design/mexp_dp.sv
design/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
